FILE: design/spi_pkg.sv
// shared types and constants for the segment intersection unit
// no dependencies; imported by every module of the block
package spi_pkg;

   // width of each coordinate port
   localparam int IN_WIDTH = 16;
   // width of the crossing point ports
   localparam int XY_WIDTH = 24;
   // number of coordinates in one request word
   localparam int NUM_PTS = 8;

   // flags that ride alongside the divider
   typedef struct packed {
      logic box_overlap;
      logic is_parallel;
   } spi_flags_type;

endpackage

FILE: design/spi_det.sv
// front end: box test, determinant and crossing numerators, six register stages
// depends on spi_pkg
module spi_det #(
   parameter int W = 16,
   parameter int F = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [spi_pkg::NUM_PTS-1:0][W-1:0] pts,
   output logic                             out_valid,
   output spi_pkg::spi_flags_type           out_flags,
   output logic [7:0][W-1:0]                out_span,
   output logic [2*W+2:0]                   out_dmag,
   output logic [1:0][3*W+2+F:0]            out_nmag,
   output logic [1:0]                       out_neg
);
   import spi_pkg::*;

   localparam int DW   = W + 1;
   localparam int PRW  = 2 * W;
   localparam int PAW  = 2 * W + 1;
   localparam int M1W  = 2 * W + 2;
   localparam int DETW = 2 * W + 3;
   localparam int TW   = 3 * W + 2;
   localparam int NW   = 3 * W + 3;
   localparam int NSW  = NW + F;

   // stage 1: input register
   logic                v1_ff;
   logic signed [W-1:0] c_ff [NUM_PTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         for (int i = 0; i < NUM_PTS; i++) begin
            c_ff[i] <= $signed(pts[i]);
         end
      end
   end

   // stage 2: differences, coordinate products, extents and box test
   logic signed [DW-1:0]  dxa_in, dya_in, dxb_in, dyb_in;
   logic signed [PRW-1:0] pa1_in, pa2_in, pb1_in, pb2_in;
   logic [7:0][W-1:0]     span_in;
   logic                  ovl_in;
   logic signed [W-1:0]   axmn, axmx, aymn, aymx, bxmn, bxmx, bymn, bymx;

   always_comb begin
      dxa_in = DW'(c_ff[0]) - DW'(c_ff[2]);
      dya_in = DW'(c_ff[1]) - DW'(c_ff[3]);
      dxb_in = DW'(c_ff[4]) - DW'(c_ff[6]);
      dyb_in = DW'(c_ff[5]) - DW'(c_ff[7]);
      pa1_in = PRW'(c_ff[0]) * PRW'(c_ff[3]);
      pa2_in = PRW'(c_ff[1]) * PRW'(c_ff[2]);
      pb1_in = PRW'(c_ff[4]) * PRW'(c_ff[7]);
      pb2_in = PRW'(c_ff[5]) * PRW'(c_ff[6]);
      axmn = (c_ff[0] < c_ff[2]) ? c_ff[0] : c_ff[2];
      axmx = (c_ff[0] > c_ff[2]) ? c_ff[0] : c_ff[2];
      aymn = (c_ff[1] < c_ff[3]) ? c_ff[1] : c_ff[3];
      aymx = (c_ff[1] > c_ff[3]) ? c_ff[1] : c_ff[3];
      bxmn = (c_ff[4] < c_ff[6]) ? c_ff[4] : c_ff[6];
      bxmx = (c_ff[4] > c_ff[6]) ? c_ff[4] : c_ff[6];
      bymn = (c_ff[5] < c_ff[7]) ? c_ff[5] : c_ff[7];
      bymx = (c_ff[5] > c_ff[7]) ? c_ff[5] : c_ff[7];
      span_in = {bymx, bymn, bxmx, bxmn, aymx, aymn, axmx, axmn};
      // touching boxes count as apart
      ovl_in = (axmx > bxmn) && (aymx > bymn) && (bxmx > axmn) && (bymx > aymn);
   end

   logic                  v2_ff, ovl2_ff;
   logic signed [DW-1:0]  dxa2_ff, dya2_ff, dxb2_ff, dyb2_ff;
   logic signed [PRW-1:0] pa1_ff, pa2_ff, pb1_ff, pb2_ff;
   logic [7:0][W-1:0]     span2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         dxa2_ff  <= dxa_in;
         dya2_ff  <= dya_in;
         dxb2_ff  <= dxb_in;
         dyb2_ff  <= dyb_in;
         pa1_ff   <= pa1_in;
         pa2_ff   <= pa2_in;
         pb1_ff   <= pb1_in;
         pb2_ff   <= pb2_in;
         span2_ff <= span_in;
         ovl2_ff  <= ovl_in;
      end
   end

   // stage 3: determinant products and the two cross terms pa, pb
   logic signed [M1W-1:0] m1_in, m2_in;
   logic signed [PAW-1:0] pa_in, pb_in;

   assign m1_in = M1W'(dxa2_ff) * M1W'(dyb2_ff);
   assign m2_in = M1W'(dya2_ff) * M1W'(dxb2_ff);
   assign pa_in = PAW'(pa1_ff) - PAW'(pa2_ff);
   assign pb_in = PAW'(pb1_ff) - PAW'(pb2_ff);

   logic                  v3_ff, ovl3_ff;
   logic signed [DW-1:0]  dxa3_ff, dya3_ff, dxb3_ff, dyb3_ff;
   logic signed [M1W-1:0] m1_ff, m2_ff;
   logic signed [PAW-1:0] pa_ff, pb_ff;
   logic [7:0][W-1:0]     span3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         dxa3_ff  <= dxa2_ff;
         dya3_ff  <= dya2_ff;
         dxb3_ff  <= dxb2_ff;
         dyb3_ff  <= dyb2_ff;
         m1_ff    <= m1_in;
         m2_ff    <= m2_in;
         pa_ff    <= pa_in;
         pb_ff    <= pb_in;
         span3_ff <= span2_ff;
         ovl3_ff  <= ovl2_ff;
      end
   end

   // stage 4: determinant and the four numerator products
   logic signed [DETW-1:0] d_in;
   logic signed [TW-1:0]   t1_in, t2_in, t3_in, t4_in;

   assign d_in  = DETW'(m1_ff) - DETW'(m2_ff);
   assign t1_in = TW'(pa_ff) * TW'(dxb3_ff);
   assign t2_in = TW'(dxa3_ff) * TW'(pb_ff);
   assign t3_in = TW'(pa_ff) * TW'(dyb3_ff);
   assign t4_in = TW'(dya3_ff) * TW'(pb_ff);

   logic                   v4_ff, ovl4_ff;
   logic signed [DETW-1:0] d4_ff;
   logic signed [TW-1:0]   t1_ff, t2_ff, t3_ff, t4_ff;
   logic [7:0][W-1:0]      span4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
      if (en) begin
         d4_ff    <= d_in;
         t1_ff    <= t1_in;
         t2_ff    <= t2_in;
         t3_ff    <= t3_in;
         t4_ff    <= t4_in;
         span4_ff <= span3_ff;
         ovl4_ff  <= ovl3_ff;
      end
   end

   // stage 5: numerators, parallel test, divisor magnitude
   logic signed [NW-1:0] nx_in, ny_in;
   logic [DETW-1:0]      dmag_in;
   logic                 par_in;

   assign nx_in   = NW'(t1_ff) - NW'(t2_ff);
   assign ny_in   = NW'(t3_ff) - NW'(t4_ff);
   assign par_in  = (d4_ff == '0);
   assign dmag_in = d4_ff[DETW-1] ? DETW'(-d4_ff) : DETW'(d4_ff);

   logic                 v5_ff, ovl5_ff, par5_ff, dneg5_ff;
   logic signed [NW-1:0] nx5_ff, ny5_ff;
   logic [DETW-1:0]      dmag5_ff;
   logic [7:0][W-1:0]    span5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
      if (en) begin
         nx5_ff   <= nx_in;
         ny5_ff   <= ny_in;
         dmag5_ff <= dmag_in;
         dneg5_ff <= d4_ff[DETW-1];
         par5_ff  <= par_in;
         span5_ff <= span4_ff;
         ovl5_ff  <= ovl4_ff;
      end
   end

   // stage 6: scale numerators by the fraction bits, split sign and magnitude
   logic signed [NSW-1:0] nxs, nys;
   logic [1:0][NSW-1:0]   nmag_in;
   logic [1:0]            neg_in;

   always_comb begin
      nxs = NSW'(nx5_ff) <<< F;
      nys = NSW'(ny5_ff) <<< F;
      nmag_in[0] = nxs[NSW-1] ? NSW'(-nxs) : NSW'(nxs);
      nmag_in[1] = nys[NSW-1] ? NSW'(-nys) : NSW'(nys);
      neg_in[0]  = nxs[NSW-1] ^ dneg5_ff;
      neg_in[1]  = nys[NSW-1] ^ dneg5_ff;
   end

   logic v6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= v5_ff;
      end
      if (en) begin
         out_nmag              <= nmag_in;
         out_neg               <= neg_in;
         out_dmag              <= dmag5_ff;
         out_span              <= span5_ff;
         out_flags.box_overlap <= ovl5_ff;
         out_flags.is_parallel <= par5_ff;
      end
   end

   assign out_valid = v6_ff;

endmodule

FILE: design/spi_div.sv
// pipelined restoring divider, two lanes sharing one divisor, one quotient bit a stage
// depends on spi_pkg
module spi_div #(
   parameter int NUMW = 59,
   parameter int DENW = 35,
   parameter int QW   = 25,
   parameter int TAGW = 130
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [DENW-1:0]      dmag,
   input  logic [1:0][NUMW-1:0] nmag,
   input  logic [1:0]           in_neg,
   input  logic [TAGW-1:0]      in_tag,
   output logic                 out_valid,
   output logic [1:0][QW-1:0]   out_quo,
   output logic [1:0]           out_neg,
   output logic [1:0]           out_ovf,
   output logic [TAGW-1:0]      out_tag
);
   import spi_pkg::*;

   localparam int CMPW = ((NUMW > DENW + QW) ? NUMW : DENW + QW) + 1;

   logic                 vld_ff [QW+1];
   logic [1:0][NUMW-1:0] rem_ff [QW];
   logic [1:0][QW-1:0]   quo_ff [QW+1];
   logic [DENW-1:0]      den_ff [QW+1];
   logic [1:0]           neg_ff [QW+1];
   logic [1:0]           ovf_ff [QW+1];
   logic [TAGW-1:0]      tag_ff [QW+1];

   // entry stage: quotients that do not fit QW bits can never land on a segment
   logic [1:0] ovf_in;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         ovf_in[l] = CMPW'(nmag[l]) >= (CMPW'(dmag) << QW);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
      if (en) begin
         rem_ff[0] <= nmag;
         quo_ff[0] <= '0;
         den_ff[0] <= dmag;
         neg_ff[0] <= in_neg;
         ovf_ff[0] <= ovf_in;
         tag_ff[0] <= in_tag;
      end
   end

   // one trial subtraction per stage, most significant quotient bit first
   for (genvar j = 1; j <= QW; j++) begin : g_stage
      localparam int B = QW - j;
      logic [1:0][CMPW-1:0] trial;
      logic [1:0]           take;
      logic [1:0][QW-1:0]   quo_in;

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            trial[l]  = CMPW'(rem_ff[j-1][l]) - (CMPW'(den_ff[j-1]) << B);
            take[l]   = !trial[l][CMPW-1];
            quo_in[l] = quo_ff[j-1][l] | (QW'(take[l]) << B);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_ff[j-1];
         end
         if (en) begin
            quo_ff[j] <= quo_in;
            den_ff[j] <= den_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
            tag_ff[j] <= tag_ff[j-1];
         end
      end

      // the last stage has no use for the remainder
      if (j < QW) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               for (int l = 0; l < 2; l++) begin
                  rem_ff[j][l] <= take[l] ? trial[l][NUMW-1:0] : rem_ff[j-1][l];
               end
            end
         end
      end
   end

   assign out_valid = vld_ff[QW];
   assign out_quo   = quo_ff[QW];
   assign out_neg   = neg_ff[QW];
   assign out_ovf   = ovf_ff[QW];
   assign out_tag   = tag_ff[QW];

endmodule

FILE: design/segment_intersection_unit_core.sv
// Segment intersection unit. Takes one pair of segments per cycle unless rsp_ready
// backpressure stalls it, and returns the strict bounding box overlap, the parallel flag
// and, on a hit, the crossing point with FRAC_BITS fraction bits truncated toward zero.
// The divider resolves one quotient bit per stage; six front stages form the determinant
// and numerators and one register holds the response word. Backpressure on rsp_ready
// stalls the whole pipeline, so req_ready follows it in the same cycle. No reset sweep.
// top level; depends on spi_pkg, spi_det and spi_div
module segment_intersection_unit_core #(
   parameter int COORD_WIDTH = 16,
   parameter int FRAC_BITS   = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [spi_pkg::IN_WIDTH-1:0] req_first_start_x,
   input  logic signed [spi_pkg::IN_WIDTH-1:0] req_first_start_y,
   input  logic signed [spi_pkg::IN_WIDTH-1:0] req_first_end_x,
   input  logic signed [spi_pkg::IN_WIDTH-1:0] req_first_end_y,
   input  logic signed [spi_pkg::IN_WIDTH-1:0] req_second_start_x,
   input  logic signed [spi_pkg::IN_WIDTH-1:0] req_second_start_y,
   input  logic signed [spi_pkg::IN_WIDTH-1:0] req_second_end_x,
   input  logic signed [spi_pkg::IN_WIDTH-1:0] req_second_end_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_box_overlap,
   output logic                                rsp_is_parallel,
   output logic                                rsp_hit,
   output logic signed [spi_pkg::XY_WIDTH-1:0] rsp_cross_x,
   output logic signed [spi_pkg::XY_WIDTH-1:0] rsp_cross_y
);
   import spi_pkg::*;

   localparam int W    = COORD_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int DETW = 2 * W + 3;
   localparam int NSW  = 3 * W + 3 + F;
   localparam int QW   = W + F + 1;
   localparam int QSW  = QW + 1;
   localparam int SPW  = 8 * W;
   localparam int TAGW = SPW + $bits(spi_flags_type);

   // whole pipeline advances when the response register is free
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // coordinates cut or widened to COORD_WIDTH
   logic [NUM_PTS-1:0][IN_WIDTH-1:0] raw;
   logic [NUM_PTS-1:0][W-1:0]        pts;

   assign raw = {req_second_end_y, req_second_end_x, req_second_start_y, req_second_start_x,
                 req_first_end_y, req_first_end_x, req_first_start_y, req_first_start_x};

   for (genvar i = 0; i < NUM_PTS; i++) begin : g_pts
      if (W <= IN_WIDTH) begin : g_cut
         assign pts[i] = raw[i][W-1:0];
      end else begin : g_pad
         assign pts[i] = {{(W - IN_WIDTH){1'b0}}, raw[i]};
      end
   end

   // front end
   logic                det_valid;
   spi_flags_type       det_flags;
   logic [7:0][W-1:0]   det_span;
   logic [DETW-1:0]     det_dmag;
   logic [1:0][NSW-1:0] det_nmag;
   logic [1:0]          det_neg;

   spi_det #(
      .W (W),
      .F (F)
   ) u_det (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .pts       (pts),
      .out_valid (det_valid),
      .out_flags (det_flags),
      .out_span  (det_span),
      .out_dmag  (det_dmag),
      .out_nmag  (det_nmag),
      .out_neg   (det_neg)
   );

   // divider
   logic               div_valid;
   logic [1:0][QW-1:0] div_quo;
   logic [1:0]         div_neg;
   logic [1:0]         div_ovf;
   logic [TAGW-1:0]    div_tag;

   spi_div #(
      .NUMW (NSW),
      .DENW (DETW),
      .QW   (QW),
      .TAGW (TAGW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (det_valid),
      .dmag      (det_dmag),
      .nmag      (det_nmag),
      .in_neg    (det_neg),
      .in_tag    ({det_flags, det_span}),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_neg   (div_neg),
      .out_ovf   (div_ovf),
      .out_tag   (div_tag)
   );

   // signed point and extent checks
   spi_flags_type          fl;
   logic [7:0][W-1:0]      sp;
   logic signed [QSW-1:0]  qx, qy;
   logic signed [QSW-1:0]  lim [8];
   logic                   hit_in;

   always_comb begin
      fl = div_tag[TAGW-1 -: $bits(spi_flags_type)];
      sp = div_tag[SPW-1:0];
      qx = div_neg[0] ? -$signed({1'b0, div_quo[0]}) : $signed({1'b0, div_quo[0]});
      qy = div_neg[1] ? -$signed({1'b0, div_quo[1]}) : $signed({1'b0, div_quo[1]});
      for (int k = 0; k < 8; k++) begin
         lim[k] = QSW'($signed(sp[k])) <<< F;
      end
      hit_in = !fl.is_parallel && !div_ovf[0] && !div_ovf[1] &&
               qx >= lim[0] && qx <= lim[1] && qx >= lim[4] && qx <= lim[5] &&
               qy >= lim[2] && qy <= lim[3] && qy >= lim[6] && qy <= lim[7];
   end

   // response word register
   logic                       rsp_valid_ff;
   logic                       ovl_ff, par_ff, hit_ff;
   logic signed [XY_WIDTH-1:0] cx_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_valid;
      end
      if (en) begin
         ovl_ff <= fl.box_overlap;
         par_ff <= fl.is_parallel;
         hit_ff <= hit_in;
         cx_ff  <= hit_in ? XY_WIDTH'(qx) : '0;
         cy_ff  <= hit_in ? XY_WIDTH'(qy) : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_box_overlap = ovl_ff;
   assign rsp_is_parallel = par_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_cross_x     = cx_ff;
   assign rsp_cross_y     = cy_ff;

endmodule

FILE: design/spi_chk.sv
// port-level checks for the segment intersection unit, bound to the top level
// depends on spi_pkg and segment_intersection_unit_core
module spi_chk (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_is_parallel,
   input logic                                rsp_hit,
   input logic signed [spi_pkg::XY_WIDTH-1:0] rsp_cross_x,
   input logic signed [spi_pkg::XY_WIDTH-1:0] rsp_cross_y
);
   import spi_pkg::*;

   // no word is offered straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a parallel pair can never hit
   a_hit_not_par: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_is_parallel)
      else $error("hit reported on parallel segments");

   // point is zero on a miss
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_cross_x == '0 && rsp_cross_y == '0)
      else $error("nonzero point without a hit");

   // a stalled response stalls the request side
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

   // a stalled response stays valid and holds its x point and hit flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cross_x) && $stable(rsp_hit))
      else $error("response changed while stalled");

endmodule

bind segment_intersection_unit_core spi_chk u_spi_chk (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_is_parallel (rsp_is_parallel),
   .rsp_hit         (rsp_hit),
   .rsp_cross_x     (rsp_cross_x),
   .rsp_cross_y     (rsp_cross_y)
);
